>>> rtl/core/bca_pkg.sv
// Shared types, constants and helper functions of the bitmap chunk allocator.
// Used by every module under rtl/core; depends on nothing else.
package bca_pkg;

  localparam int MAX_CHUNKS    = 256;
  localparam int HEADER_BYTES  = 4;

  localparam int BITMAP_BYTES  = (MAX_CHUNKS + 7) / 8;
  localparam int BYTE_SEL_W    = $clog2(BITMAP_BYTES);
  localparam int BYTE_CNT_W    = $clog2(BITMAP_BYTES + 1);
  localparam int COUNT_W       = 9;
  localparam int INDEX_W       = 8;
  localparam int OFFSET_W      = 24;
  localparam int CHUNK_BYTES_W = 16;
  localparam int STRIDE_W      = CHUNK_BYTES_W + 1;
  localparam int PROD_W        = INDEX_W + STRIDE_W;
  localparam int STATUS_W      = 2;

  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_BYTES   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CHUNKS_IN_USE = CFG_INDEX_W'(1);

  localparam logic [CHUNK_BYTES_W-1:0] CHUNK_BYTES_RESET = CHUNK_BYTES_W'(64);
  localparam logic [COUNT_W-1:0]       CHUNKS_RESET      = COUNT_W'(256);
  localparam logic [7:0]               BYTE_ALL_FREE     = 8'hff;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_DOUBLE = 2'd3
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic [OFFSET_W-1:0] offset;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [INDEX_W-1:0]  index;
    logic [OFFSET_W-1:0] offset;
  } result_t;

  // Handshake between the input queue and the executing back end.
  typedef struct packed {
    logic  empty;
    item_t head;
  } front_out_t;

  // Position of the lowest set bit; an all-zero byte gives seven.
  function automatic logic [2:0] lowest_bit(input logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (b[i]) begin
        pos = 3'(i);
      end
    end
    return pos;
  endfunction

endpackage

>>> rtl/core/bca_front.sv
// Front end of the chunk allocator: accepts request words, decodes the
// operation and holds them in a short queue for the back end. Uses bca_pkg.
module bca_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         op,
  input  logic [bca_pkg::OFFSET_W-1:0] free_offset,
  input  logic                         deq,
  output bca_pkg::front_out_t          fout
);
  import bca_pkg::*;

  item_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   cnt;
  logic                do_push;
  logic                do_pop;
  item_t               item_in;

  assign full    = (cnt == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = deq && (cnt != '0);

  always_comb begin
    item_in.op     = op ? OP_FREE : OP_ALLOC;
    // The offset only matters to a free; an allocate carries zero.
    item_in.offset = op ? free_offset : '0;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - QCNT_W'(1);
      end
    end
  end

  assign fout.empty = (cnt == '0);
  assign fout.head  = slots[rd_ptr];

endmodule

>>> rtl/core/bca_div.sv
// Restoring divider, one quotient bit per cycle, used to turn a payload offset
// into a chunk index. Uses bca_pkg for widths.
module bca_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bca_pkg::OFFSET_W-1:0] dividend,
  input  logic [bca_pkg::STRIDE_W-1:0] divisor,
  output logic                         done,
  output logic [bca_pkg::OFFSET_W-1:0] quotient
);
  import bca_pkg::*;

  localparam int STEP_W = $clog2(OFFSET_W);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [OFFSET_W-1:0] dvd;
  logic [STRIDE_W-1:0] rem;
  logic [STRIDE_W:0]   trial;
  logic [STRIDE_W:0]   diff;
  logic                ge;

  assign trial = {rem, dvd[OFFSET_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[OFFSET_W-2:0], ge};
      rem <= ge ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(OFFSET_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // After the last step the shifted dividend holds the quotient.
  assign quotient = dvd;

endmodule

>>> rtl/core/bca_back.sv
// Back end of the chunk allocator: owns the free bitmap, runs the allocate
// scan and the free check, and queues result words. Uses bca_pkg and bca_div.
module bca_back (
  input  logic                         clk,
  input  logic                         rst,
  input  bca_pkg::front_out_t          fout,
  output logic                         deq,
  input  logic [bca_pkg::STRIDE_W-1:0] stride,
  input  logic [bca_pkg::COUNT_W-1:0]  count,
  input  logic                         pop,
  output logic                         empty,
  output logic [bca_pkg::STATUS_W-1:0] status,
  output logic [bca_pkg::INDEX_W-1:0]  chunk_index,
  output logic [bca_pkg::OFFSET_W-1:0] chunk_offset
);
  import bca_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_MUL   = 6'b000100,
    S_ADD   = 6'b001000,
    S_DIV   = 6'b010000,
    S_CHECK = 6'b100000
  } state_t;

  state_t                state;
  logic [7:0]            bitmap [BITMAP_BYTES];
  logic [BYTE_CNT_W-1:0] byte_ix;
  logic [BYTE_CNT_W-1:0] nbytes;
  logic [INDEX_W-1:0]    idx;
  logic [PROD_W-1:0]     prod;
  logic [OFFSET_W-1:0]   quot_q;

  logic                  div_start;
  logic                  div_done;
  logic [OFFSET_W-1:0]   quot;

  logic [7:0]            scan_byte;
  logic [2:0]            scan_pos;
  logic [BYTE_SEL_W-1:0] free_sel;
  logic [2:0]            free_bit;
  logic                  out_of_range;

  result_t               res_slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     res_wr;
  logic [QPTR_W-1:0]     res_rd;
  logic [QCNT_W-1:0]     res_cnt;
  logic                  res_push;
  result_t               res_in;
  logic                  res_pop;

  bca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (fout.head.offset),
    .divisor  (stride),
    .done     (div_done),
    .quotient (quot)
  );

  assign nbytes       = count[COUNT_W-1:3];
  assign scan_byte    = bitmap[byte_ix[BYTE_SEL_W-1:0]];
  assign scan_pos     = lowest_bit(scan_byte);
  assign free_sel     = quot_q[BYTE_SEL_W+2:3];
  assign free_bit     = quot_q[2:0];
  assign out_of_range = (quot_q >= OFFSET_W'(count));

  // A new word is taken only when the result queue can absorb its result.
  assign deq       = (state == S_IDLE) && !fout.empty && (res_cnt < QCNT_W'(QUEUE_DEPTH));
  assign div_start = deq && (fout.head.op == OP_FREE);

  always_comb begin
    res_push = 1'b0;
    res_in   = '{status: STAT_OK, index: '0, offset: '0};
    case (state)
      S_SCAN: begin
        if (byte_ix == nbytes) begin
          res_push      = 1'b1;
          res_in.status = STAT_FULL;
        end
      end
      S_ADD: begin
        res_push      = 1'b1;
        res_in.index  = idx;
        res_in.offset = prod[OFFSET_W-1:0] + OFFSET_W'(HEADER_BYTES);
      end
      S_CHECK: begin
        res_push = 1'b1;
        if (out_of_range) begin
          res_in.status = STAT_RANGE;
        end else begin
          res_in.index  = quot_q[INDEX_W-1:0];
          res_in.status = bitmap[free_sel][free_bit] ? STAT_DOUBLE : STAT_OK;
        end
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      byte_ix <= '0;
      for (int i = 0; i < BITMAP_BYTES; i++) begin
        bitmap[i] <= BYTE_ALL_FREE;
      end
    end else begin
      case (state)
        S_IDLE: begin
          byte_ix <= '0;
          if (deq) begin
            state <= (fout.head.op == OP_FREE) ? S_DIV : S_SCAN;
          end
        end
        S_SCAN: begin
          if (byte_ix == nbytes) begin
            state <= S_IDLE;
          end else if (scan_byte != '0) begin
            bitmap[byte_ix[BYTE_SEL_W-1:0]][scan_pos] <= 1'b0;
            state <= S_MUL;
          end else begin
            byte_ix <= byte_ix + BYTE_CNT_W'(1);
          end
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          state <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!out_of_range) begin
            bitmap[free_sel][free_bit] <= 1'b1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      idx <= {byte_ix[BYTE_SEL_W-1:0], scan_pos};
    end
    if (state == S_MUL) begin
      prod <= PROD_W'(idx) * PROD_W'(stride);
    end
    if (div_done) begin
      quot_q <= quot;
    end
  end

  // Result queue; it lets the back end finish while the receiver stalls.
  assign res_pop = pop && !empty;
  assign empty   = (res_cnt == '0);

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_slots[res_wr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr  <= '0;
      res_rd  <= '0;
      res_cnt <= '0;
    end else begin
      if (res_push) begin
        res_wr <= res_wr + QPTR_W'(1);
      end
      if (res_pop) begin
        res_rd <= res_rd + QPTR_W'(1);
      end
      if (res_push && !res_pop) begin
        res_cnt <= res_cnt + QCNT_W'(1);
      end else if (res_pop && !res_push) begin
        res_cnt <= res_cnt - QCNT_W'(1);
      end
    end
  end

  assign status       = res_slots[res_rd].status;
  assign chunk_index  = res_slots[res_rd].index;
  assign chunk_offset = res_slots[res_rd].offset;

endmodule

>>> rtl/core/bitmap_chunk_allocator.sv
// Bitmap chunk allocator, one managed block of up to MAX_CHUNKS chunks.
//
// Request channel: push/full. Each word carries op (allocate or free) and
// free_offset; it enters a two-entry queue whenever full is low.
// Result channel: empty/pop. While empty is low the oldest result word is on
// status, chunk_index and chunk_offset; pop takes it. Two result words can
// wait, so a stalled receiver backs up into the request queue and then full.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0 sets
// the chunk payload size, index 1 the number of chunks; other indexes are
// dropped. cfg_ready is always high; writes belong to idle periods.
// Processing: an allocate scans the bitmap one byte per cycle and takes the
// first byte that has a free chunk, then multiplies the index by the stride
// and adds the header to form the offset; a full bitmap answers once all
// count/8 bytes are scanned. A free runs the bit-serial divider, then the
// range check and bitmap update. One request is worked on at a time; the
// next one is taken once the back end is idle again and the result queue
// has room.
// Reset (synchronous, active high) marks every chunk free, restores the
// register defaults and empties both queues.
module bitmap_chunk_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            op,
  input  logic [bca_pkg::OFFSET_W-1:0]    free_offset,
  output logic                            empty,
  input  logic                            pop,
  output logic [bca_pkg::STATUS_W-1:0]    status,
  output logic [bca_pkg::INDEX_W-1:0]     chunk_index,
  output logic [bca_pkg::OFFSET_W-1:0]    chunk_offset,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bca_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bca_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bca_pkg::*;

  logic [CHUNK_BYTES_W-1:0] chunk_bytes;
  logic [COUNT_W-1:0]       chunks_in_use;
  logic [STRIDE_W-1:0]      stride;
  logic [COUNT_W:0]         rounded;
  logic [COUNT_W-1:0]       count;
  front_out_t               fout;
  logic                     deq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes   <= CHUNK_BYTES_RESET;
      chunks_in_use <= CHUNKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHUNK_BYTES:   chunk_bytes   <= cfg_data;
        REG_CHUNKS_IN_USE: chunks_in_use <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A zero payload size behaves as one byte.
  assign stride = ((chunk_bytes == '0) ? STRIDE_W'(1) : STRIDE_W'(chunk_bytes))
                  + STRIDE_W'(HEADER_BYTES);

  // Chunk count rounded up to whole bitmap bytes and limited to the bitmap.
  always_comb begin
    rounded      = {1'b0, chunks_in_use} + (COUNT_W+1)'(7);
    rounded[2:0] = 3'b000;
    if (rounded > (COUNT_W+1)'(BITMAP_BYTES * 8)) begin
      count = COUNT_W'(BITMAP_BYTES * 8);
    end else begin
      count = rounded[COUNT_W-1:0];
    end
  end

  bca_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .op          (op),
    .free_offset (free_offset),
    .deq         (deq),
    .fout        (fout)
  );

  bca_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fout         (fout),
    .deq          (deq),
    .stride       (stride),
    .count        (count),
    .pop          (pop),
    .empty        (empty),
    .status       (status),
    .chunk_index  (chunk_index),
    .chunk_offset (chunk_offset)
  );

endmodule

>>> bench/bitmap_chunk_allocator_test.sv
// Self-checking testbench for bitmap_chunk_allocator: a bitmap predictor, directed
// and random allocate/free traffic, register changes and back-pressure phases.
// Depends on bca_pkg and the bitmap_chunk_allocator RTL only.
`timescale 1ns / 1ps

module bitmap_chunk_allocator_test;
  import bca_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int STALL_CYCLES = 300;
  localparam int SETTLE_CYCLES = 64;
  localparam int REPORT_MAX   = 10;

  // Register indexes that the block has no register for.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic                   op = 1'b0;
  logic [OFFSET_W-1:0]    free_offset = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [INDEX_W-1:0]     chunk_index;
  logic [OFFSET_W-1:0]    chunk_offset;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  bitmap_chunk_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .free_offset  (free_offset),
    .empty        (empty),
    .pop          (pop),
    .status       (status),
    .chunk_index  (chunk_index),
    .chunk_offset (chunk_offset),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Mirror of the allocator state.
  logic [7:0]               free_map [BITMAP_BYTES];
  logic [CHUNK_BYTES_W-1:0] model_chunk_bytes = CHUNK_BYTES_RESET;
  logic [COUNT_W-1:0]       model_chunk_count = CHUNKS_RESET;

  result_t expected_words [$];
  result_t want;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_requests = 0;
  int stall_served = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int errors = 0;
  int items_sent = 0;
  int words_checked = 0;
  int alloc_ok_n = 0;
  int full_n = 0;
  int range_n = 0;
  int double_n = 0;
  int freed_n = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int eff_count();
    int n;
    n = (int'(model_chunk_count) + 7) & ~7;
    if (n > BITMAP_BYTES * 8) begin
      n = BITMAP_BYTES * 8;
    end
    return n;
  endfunction

  function automatic int slot_stride();
    return ((model_chunk_bytes == '0) ? 1 : int'(model_chunk_bytes)) + HEADER_BYTES;
  endfunction

  // Computes the result word of one request and updates the mirrored bitmap.
  function automatic result_t allocator_predict(op_t req_op, logic [OFFSET_W-1:0] req_off);
    result_t r;
    int cnt;
    int strd;
    int idx;
    r = '0;
    cnt = eff_count();
    strd = slot_stride();
    idx = -1;
    if (req_op == OP_ALLOC) begin
      for (int b = 0; b < cnt / 8; b++) begin
        if (idx < 0 && free_map[b] != 8'h00) begin
          for (int p = 7; p >= 0; p--) begin
            if (free_map[b][p]) idx = b * 8 + p;
          end
        end
      end
      if (idx < 0) begin
        r.status = STAT_FULL;
        full_n++;
      end else begin
        free_map[idx / 8][idx % 8] = 1'b0;
        r.status = STAT_OK;
        r.index = INDEX_W'(idx);
        r.offset = OFFSET_W'(idx * strd + HEADER_BYTES);
        alloc_ok_n++;
      end
    end else begin
      idx = int'({8'h00, req_off}) / strd;
      if (idx >= cnt) begin
        r.status = STAT_RANGE;
        range_n++;
      end else if (free_map[idx / 8][idx % 8]) begin
        // Already free: reported, and the bit is left set.
        r.status = STAT_DOUBLE;
        r.index = INDEX_W'(idx);
        double_n++;
      end else begin
        free_map[idx / 8][idx % 8] = 1'b1;
        r.status = STAT_OK;
        r.index = INDEX_W'(idx);
        freed_n++;
      end
    end
    return r;
  endfunction

  // Allocated chunk at or after start, wrapping, or -1 when all are free.
  function automatic int busy_chunk(int start);
    int cnt;
    int i;
    cnt = eff_count();
    for (int k = 0; k < cnt; k++) begin
      i = (start + k) % cnt;
      if (!free_map[i / 8][i % 8]) return i;
    end
    return -1;
  endfunction

  task automatic send_request(input op_t req_op, input logic [OFFSET_W-1:0] req_off);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    op <= req_op;
    free_offset <= req_off;
    do @(posedge clk); while (full);
    expected_words.push_back(allocator_predict(req_op, req_off));
    items_sent++;
  endtask

  // Holds the request side until every expected word has been taken.
  task automatic wait_results_drained();
    push <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_CHUNK_BYTES) begin
      model_chunk_bytes = data;
    end else if (idx == REG_CHUNKS_IN_USE) begin
      model_chunk_count = data[COUNT_W-1:0];
    end
  endtask

  task automatic random_request(input int alloc_pct, output op_t r_op,
                                output logic [OFFSET_W-1:0] r_off);
    int cnt;
    int strd;
    int idx;
    int kind;
    cnt = eff_count();
    strd = slot_stride();
    r_off = OFFSET_W'($urandom);
    if ($urandom_range(99) < alloc_pct) begin
      r_op = OP_ALLOC;
    end else begin
      r_op = OP_FREE;
      kind = $urandom_range(99);
      if (cnt > 0 && kind < 85) begin
        // Mostly frees of chunks in use, some of chunks already free.
        idx = (kind < 70) ? busy_chunk($urandom_range(cnt - 1)) : $urandom_range(cnt - 1);
        if (idx >= 0) r_off = OFFSET_W'(idx * strd + $urandom_range(strd - 1));
      end else if (kind < 93) begin
        r_off = OFFSET_W'(cnt * strd + $urandom_range(strd - 1));
      end
    end
  endtask

  task automatic run_random(input int n, input int alloc_pct);
    op_t r_op;
    logic [OFFSET_W-1:0] r_off;
    repeat (n) begin
      random_request(alloc_pct, r_op, r_off);
      send_request(r_op, r_off);
    end
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] cb;
    logic [CFG_DATA_W-1:0] cnt;
    case ($urandom_range(4))
      0: cb = '0;
      1: cb = 16'd1;
      2: cb = 16'hffff;
      3: cb = CFG_DATA_W'($urandom_range(1, 200));
      default: cb = CFG_DATA_W'($urandom);
    endcase
    case ($urandom_range(5))
      0: cnt = 16'd8;
      1: cnt = 16'd16;
      2: cnt = 16'd256;
      3: cnt = CFG_DATA_W'($urandom_range(1, 64));
      4: cnt = CFG_DATA_W'($urandom);
      default: cnt = 16'd24;
    endcase
    write_register(REG_CHUNK_BYTES, cb);
    write_register(REG_CHUNKS_IN_USE, cnt);
  endtask

  task automatic test_basic_alloc_free();
    send_request(OP_ALLOC, 24'hffffff);
    send_request(OP_ALLOC, 24'h000000);
    send_request(OP_FREE, 24'd72);
    send_request(OP_FREE, 24'd72);
    // An offset inside the header still maps to its slot.
    send_request(OP_FREE, 24'd2);
    send_request(OP_FREE, 24'hffffff);
    send_request(OP_FREE, 24'd17408);
  endtask

  task automatic test_tiny_chunks_until_full();
    write_register(REG_CHUNK_BYTES, 16'd0);
    write_register(REG_CHUNKS_IN_USE, 16'd8);
    repeat (9) send_request(OP_ALLOC, 24'h000000);
  endtask

  task automatic test_zero_count();
    write_register(REG_CHUNKS_IN_USE, 16'd0);
    send_request(OP_ALLOC, 24'h000000);
    send_request(OP_FREE, 24'd4);
  endtask

  task automatic test_wide_stride_and_spare_regs();
    write_register(REG_CHUNK_BYTES, 16'hffff);
    write_register(REG_CHUNKS_IN_USE, 16'hffff);
    write_register(REG_SPARE_A, 16'h0001);
    write_register(REG_SPARE_B, 16'h0000);
    send_request(OP_ALLOC, 24'h000000);
    send_request(OP_FREE, 24'hffffff);
    // Upper data bits are dropped, leaving a count of one, rounded up to eight.
    write_register(REG_CHUNKS_IN_USE, 16'hfe01);
    send_request(OP_ALLOC, 24'h000000);
    send_request(OP_FREE, 24'd65543);
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int k = 0; k < 6; k++) begin
      random_config();
      run_random(50, $urandom_range(35, 75));
    end
  endtask

  task automatic test_receiver_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_register(REG_CHUNK_BYTES, 16'd64);
    write_register(REG_CHUNKS_IN_USE, 16'd32);
    stall_requests++;
    run_random(40, 60);
    wait_results_drained();
    run_random(20, 40);
  endtask

  // Result side: checks each popped word and drives pop for the next cycle.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("unexpected result word: status %0d index %0d offset %0h",
                 status, chunk_index, chunk_offset);
      end else begin
        want = expected_words.pop_front();
        if (status != want.status || chunk_index != want.index ||
            chunk_offset != want.offset) begin
          mismatches++;
          errors++;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch at word %0d: status %0d/%0d index %0d/%0d offset %0h/%0h",
                     words_checked, want.status, status, want.index, chunk_index,
                     want.offset, chunk_offset);
          end
        end
      end
    end
    if (stall_served != stall_requests) begin
      stall_served = stall_requests;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               expected_words.size());
      $display("bitmap_chunk_allocator_test: done, errors");
      $finish;
    end
  end

  initial begin
    foreach (free_map[i]) free_map[i] = BYTE_ALL_FREE;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_basic_alloc_free();
    test_tiny_chunks_until_full();
    test_zero_count();
    test_wide_stride_and_spare_regs();
    test_random_traffic(9, 45);
    test_receiver_stall();
    test_random_traffic(45, 9);
    test_random_traffic(0, 0);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) errors++;
    $display("%0d requests, %0d result words checked in %0d cycles, %0d mismatches",
             items_sent, words_checked, cycle_count, mismatches);
    $display("allocated %0d, full %0d, freed %0d, out of range %0d, double free %0d",
             alloc_ok_n, full_n, freed_n, range_n, double_n);
    if (errors == 0) begin
      $display("bitmap_chunk_allocator_test: done, clean");
    end else begin
      $display("bitmap_chunk_allocator_test: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bca_pkg.sv
rtl/core/bca_front.sv
rtl/core/bca_div.sv
rtl/core/bca_back.sv
rtl/core/bitmap_chunk_allocator.sv
bench/bitmap_chunk_allocator_test.sv
